>>> design/brm_pkg.sv
// Package for the byte rate meter: widths, input mode codes, queue and command types.
// It holds the divider job and state types as well, and is used by every module of the block.
// It depends on nothing.
package brm_pkg;

  localparam int COUNT_BITS = 32;
  localparam int TPS_W      = 30;
  localparam int SIZE_W     = 31;
  localparam int RATE_W     = 31;
  localparam int MODE_W     = 3;
  localparam int ELAPSED_W  = 64;
  localparam int ADD_W      = (COUNT_BITS > SIZE_W) ? COUNT_BITS : SIZE_W;
  localparam int PROD_W     = COUNT_BITS + TPS_W;
  localparam int ITER_W     = $clog2(PROD_W);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TPS_W-1:0]  TPS_RESET = TPS_W'(1000000);
  localparam logic [RATE_W-1:0] RATE_MAX  = '1;

  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_AUDIO   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_VIDEO   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RESTART = 3'd4;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_AUDIO,
    CMD_VIDEO,
    CMD_QUERY,
    CMD_RESTART
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] audio;
    logic [COUNT_BITS-1:0] video;
    logic [COUNT_BITS-1:0] total;
    logic [ELAPSED_W-1:0]  div;
    logic [TPS_W-1:0]      tps;
  } job_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_DIV,
    DV_DONE
  } div_state_e;

endpackage

>>> design/brm_front.sv
// Front end of the byte rate meter: classifies input words and queues them for the back end.
// Depends on brm_pkg.
module brm_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [brm_pkg::MODE_W-1:0]    mode_i,
  input  logic [brm_pkg::SIZE_W-1:0]    packet_size_i,
  input  logic                          pop_i,
  output brm_pkg::entry_t               head_o,
  output brm_pkg::qstat_t               stat_o
);

  brm_pkg::entry_t                 mem_q [brm_pkg::QUEUE_DEPTH];
  logic [brm_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [brm_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [brm_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  brm_pkg::cmd_e                   cmd;
  logic                            keep;
  logic                            push;
  logic                            full;

  always_comb begin
    keep = 1'b1;
    cmd  = brm_pkg::CMD_TICK;
    unique case (mode_i)
      brm_pkg::MODE_TICK:    cmd = brm_pkg::CMD_TICK;
      brm_pkg::MODE_AUDIO:   cmd = brm_pkg::CMD_AUDIO;
      brm_pkg::MODE_VIDEO:   cmd = brm_pkg::CMD_VIDEO;
      brm_pkg::MODE_QUERY:   cmd = brm_pkg::CMD_QUERY;
      brm_pkg::MODE_RESTART: cmd = brm_pkg::CMD_RESTART;
      default:               keep = 1'b0;
    endcase
  end

  assign full       = (cnt_q == brm_pkg::QCNT_W'(brm_pkg::QUEUE_DEPTH));
  assign in_ready_o = !full;
  assign push       = in_valid_i && !full && keep;

  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + brm_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + brm_pkg::QPTR_W'(1) : rd_ptr_q;
    unique case ({push, pop_i})
      2'b10:   cnt_d = cnt_q + brm_pkg::QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - brm_pkg::QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{cmd: cmd, size: packet_size_i};
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = full;

endmodule

>>> design/brm_back.sv
// Back end of the byte rate meter: holds the tick rate, the byte counters and the elapsed time.
// It carries out queued words and hands each query to the divider. Depends on brm_pkg.
module brm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brm_pkg::TPS_W-1:0]     cfg_wdata_i,
  input  brm_pkg::entry_t               head_i,
  input  brm_pkg::qstat_t               stat_i,
  output logic                          pop_o,
  input  logic                          job_ready_i,
  output logic                          job_start_o,
  output brm_pkg::job_t                 job_o
);

  logic [brm_pkg::TPS_W-1:0]      tps_q;
  logic [brm_pkg::ELAPSED_W-1:0]  elapsed_q, elapsed_d;
  logic [brm_pkg::COUNT_BITS-1:0] audio_q, audio_d;
  logic [brm_pkg::COUNT_BITS-1:0] video_q, video_d;
  logic [brm_pkg::ELAPSED_W-1:0]  div;
  logic [brm_pkg::ADD_W-1:0]      audio_sum, video_sum;

  assign div       = (elapsed_q == '0) ? brm_pkg::ELAPSED_W'(1) : elapsed_q;
  assign audio_sum = brm_pkg::ADD_W'(audio_q) + brm_pkg::ADD_W'(head_i.size);
  assign video_sum = brm_pkg::ADD_W'(video_q) + brm_pkg::ADD_W'(head_i.size);

  assign job_o.audio = audio_q;
  assign job_o.video = video_q;
  assign job_o.total = audio_q + video_q;
  assign job_o.div   = div;
  assign job_o.tps   = tps_q;

  always_comb begin
    elapsed_d   = elapsed_q;
    audio_d     = audio_q;
    video_d     = video_q;
    pop_o       = 1'b0;
    job_start_o = 1'b0;
    if (stat_i.valid) begin
      unique case (head_i.cmd)
        brm_pkg::CMD_TICK: begin
          pop_o     = 1'b1;
          elapsed_d = elapsed_q + brm_pkg::ELAPSED_W'(1);
        end
        brm_pkg::CMD_AUDIO: begin
          pop_o   = 1'b1;
          audio_d = audio_sum[brm_pkg::COUNT_BITS-1:0];
        end
        brm_pkg::CMD_VIDEO: begin
          pop_o   = 1'b1;
          video_d = video_sum[brm_pkg::COUNT_BITS-1:0];
        end
        brm_pkg::CMD_QUERY: begin
          if (job_ready_i) begin
            pop_o       = 1'b1;
            job_start_o = 1'b1;
            elapsed_d   = elapsed_q - (div >> 1);
            audio_d     = audio_q >> 1;
            video_d     = video_q >> 1;
          end
        end
        brm_pkg::CMD_RESTART: begin
          pop_o     = 1'b1;
          elapsed_d = '0;
          audio_d   = '0;
          video_d   = '0;
        end
        default: pop_o = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q     <= brm_pkg::TPS_RESET;
      elapsed_q <= '0;
      audio_q   <= '0;
      video_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
      elapsed_q <= elapsed_d;
      audio_q   <= audio_d;
      video_q   <= video_d;
    end
  end

endmodule

>>> design/brm_rate_div.sv
// Rate divider of the byte rate meter: multiplies each count by the tick rate and divides
// by the elapsed time one quotient bit a cycle, then holds the three rates for output.
// Depends on brm_pkg.
module brm_rate_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_start_i,
  input  brm_pkg::job_t                 job_i,
  output logic                          job_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [brm_pkg::RATE_W-1:0]    audio_rate_o,
  output logic [brm_pkg::RATE_W-1:0]    video_rate_o,
  output logic [brm_pkg::RATE_W-1:0]    total_rate_o
);

  localparam int NumRates = 3;
  localparam int SelW     = $clog2(NumRates);

  brm_pkg::div_state_e             state_q, state_d;
  logic [SelW-1:0]                 sel_q, sel_d;
  logic [brm_pkg::ITER_W-1:0]      iter_q, iter_d;
  logic                            out_valid_q, out_valid_d;

  logic [brm_pkg::COUNT_BITS-1:0]  cnt_q [NumRates];
  logic [brm_pkg::ELAPSED_W-1:0]   div_q;
  logic [brm_pkg::TPS_W-1:0]       tps_q;
  logic [brm_pkg::PROD_W-1:0]      prod_q;
  logic [brm_pkg::ELAPSED_W-1:0]   rem_q;
  logic [brm_pkg::RATE_W-1:0]      quo_q;
  logic                            sat_q;
  logic [brm_pkg::RATE_W-1:0]      rate_q [NumRates];
  logic [brm_pkg::RATE_W-1:0]      audio_q, video_q, total_q;

  logic                            load_job, do_mul, do_step, store_rate, load_out;
  logic [brm_pkg::PROD_W-1:0]      mul_w;
  logic [brm_pkg::ELAPSED_W:0]     rem_sh, div_ext, rem_sub;
  logic                            ge;
  logic [brm_pkg::ELAPSED_W-1:0]   rem_nx;
  logic [brm_pkg::RATE_W-1:0]      quo_nx;
  logic                            sat_nx;
  logic                            last_iter;

  assign mul_w     = brm_pkg::PROD_W'(cnt_q[sel_q]) * brm_pkg::PROD_W'(tps_q);
  assign rem_sh    = {rem_q, prod_q[brm_pkg::PROD_W-1]};
  assign div_ext   = {1'b0, div_q};
  assign ge        = (rem_sh >= div_ext);
  assign rem_sub   = rem_sh - div_ext;
  assign rem_nx    = ge ? rem_sub[brm_pkg::ELAPSED_W-1:0] : rem_sh[brm_pkg::ELAPSED_W-1:0];
  assign quo_nx    = {quo_q[brm_pkg::RATE_W-2:0], ge};
  assign sat_nx    = sat_q | quo_q[brm_pkg::RATE_W-1];
  assign last_iter = (iter_q == brm_pkg::ITER_W'(brm_pkg::PROD_W - 1));

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q;
    load_job    = 1'b0;
    do_mul      = 1'b0;
    do_step     = 1'b0;
    store_rate  = 1'b0;
    load_out    = 1'b0;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      brm_pkg::DV_IDLE: begin
        if (job_start_i) begin
          load_job = 1'b1;
          sel_d    = '0;
          state_d  = brm_pkg::DV_MUL;
        end
      end
      brm_pkg::DV_MUL: begin
        do_mul  = 1'b1;
        iter_d  = '0;
        state_d = brm_pkg::DV_DIV;
      end
      brm_pkg::DV_DIV: begin
        do_step = 1'b1;
        iter_d  = iter_q + brm_pkg::ITER_W'(1);
        if (last_iter) begin
          store_rate = 1'b1;
          if (sel_q == SelW'(NumRates - 1)) begin
            state_d = brm_pkg::DV_DONE;
          end else begin
            sel_d   = sel_q + SelW'(1);
            state_d = brm_pkg::DV_MUL;
          end
        end
      end
      brm_pkg::DV_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = brm_pkg::DV_IDLE;
        end
      end
      default: state_d = brm_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= brm_pkg::DV_IDLE;
      sel_q       <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_job) begin
      cnt_q[0] <= job_i.audio;
      cnt_q[1] <= job_i.video;
      cnt_q[2] <= job_i.total;
      div_q    <= job_i.div;
      tps_q    <= job_i.tps;
    end
    if (do_mul) begin
      prod_q <= mul_w;
      rem_q  <= '0;
      quo_q  <= '0;
      sat_q  <= 1'b0;
    end
    if (do_step) begin
      prod_q <= {prod_q[brm_pkg::PROD_W-2:0], 1'b0};
      rem_q  <= rem_nx;
      quo_q  <= quo_nx;
      sat_q  <= sat_nx;
    end
    if (store_rate) begin
      rate_q[sel_q] <= sat_nx ? brm_pkg::RATE_MAX : quo_nx;
    end
    if (load_out) begin
      audio_q <= rate_q[0];
      video_q <= rate_q[1];
      total_q <= rate_q[2];
    end
  end

  assign job_ready_o  = (state_q == brm_pkg::DV_IDLE);
  assign out_valid_o  = out_valid_q;
  assign audio_rate_o = audio_q;
  assign video_rate_o = video_q;
  assign total_rate_o = total_q;

endmodule

>>> design/byte_rate_meter_unit.sv
// Byte rate meter top level: front queue, counter back end and rate divider.
// Ticks, packets and restarts are taken one word a cycle while the queue has room; each is
// written into the queue and then into the counters. A query raises its result word once the
// bit-serial divider has all three rates; words behind it wait until the divider is free, and
// the input stalls once the four-entry queue is full. Reset is asynchronous and active low; it
// clears counters, elapsed time and the queue and loads the default tick rate. Depends on brm_pkg.
module byte_rate_meter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brm_pkg::TPS_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [brm_pkg::MODE_W-1:0]    mode_i,
  input  logic [brm_pkg::SIZE_W-1:0]    packet_size_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [brm_pkg::RATE_W-1:0]    audio_rate_o,
  output logic [brm_pkg::RATE_W-1:0]    video_rate_o,
  output logic [brm_pkg::RATE_W-1:0]    total_rate_o
);

  brm_pkg::entry_t head;
  brm_pkg::qstat_t qstat;
  brm_pkg::job_t   job;
  logic            pop;
  logic            job_ready;
  logic            job_start;

  brm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .packet_size_i (packet_size_i),
    .pop_i         (pop),
    .head_o        (head),
    .stat_o        (qstat)
  );

  brm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .stat_i      (qstat),
    .pop_o       (pop),
    .job_ready_i (job_ready),
    .job_start_o (job_start),
    .job_o       (job)
  );

  brm_rate_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_start_i  (job_start),
    .job_i        (job),
    .job_ready_o  (job_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .audio_rate_o (audio_rate_o),
    .video_rate_o (video_rate_o),
    .total_rate_o (total_rate_o)
  );

`ifndef SYNTHESIS
  a_start_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_start |-> job_ready)
    else $error("Query handed to a busy divider.");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_start |=> !job_ready)
    else $error("Divider did not take the query.");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> qstat.valid)
    else $error("Word popped from an empty queue.");

  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> qstat.valid)
    else $error("Queue reports full with no word at its head.");
`endif

endmodule
